// ===== rtl/stbs_pkg.sv =====
// Package for the sorted-table binary search block: sizes, action codes,
// search request type and the key/entry word conversion. No dependencies.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths fixed by the stream format
  localparam int ENTRY_W = 8;
  localparam int VALUE_W = 32;
  localparam int FIRST_W = 8;
  localparam int LAST_W  = 9;

  // Search bounds: lo reaches 256, hi reaches -1, plus headroom for the sign
  localparam int IDX_W = 10;

  // Highest index a search may probe (field range caps it at 255)
  localparam int LAST_MAX = (TABLE_DEPTH - 1 > 255) ? 255 : TABLE_DEPTH - 1;
  localparam logic signed [IDX_W-1:0] HI_MAX = IDX_W'(LAST_MAX);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [IDX_W-1:0]      idx_t;

  typedef struct packed {
    word_t key;
    idx_t  lo;
    idx_t  hi;
  } stbs_req_t;

  // Low WORD_WIDTH bits of the field, or the field sign-extended when wider
  function automatic word_t word_from_field(logic signed [VALUE_W-1:0] raw);
    return WORD_WIDTH'(raw);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone, no package dependency.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/stbs_engine.sv =====
// Binary search sequencer: halves [lo, hi] with an equal and a less-than compare
// per probe, reading the table RAM at the midpoint. Depends on stbs_pkg.
`default_nettype none

module stbs_engine import stbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  stbs_req_t         req_i,
  output logic              idle_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  word_t             rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              found_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  word_t      key_q, key_d;
  idx_t       lo_q, lo_d;
  idx_t       hi_q, hi_d;
  idx_t       mid_q, mid_d;
  logic       found_q, found_d;

  logic signed [IDX_W:0] mid_sum;
  idx_t                  mid;
  logic                  range_ok;

  assign mid_sum  = {lo_q[IDX_W-1], lo_q} + {hi_q[IDX_W-1], hi_q};
  assign mid      = mid_sum[IDX_W:1];  // never negative while lo <= hi
  assign range_ok = (lo_q <= hi_q);

  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    found_d  = found_q;
    re_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = req_i.key;
          lo_d    = req_i.lo;
          hi_d    = (req_i.hi > HI_MAX) ? HI_MAX : req_i.hi;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (range_ok) begin
          re_o    = 1'b1;
          mid_d   = mid;
          state_d = ST_CMP;
        end else begin
          found_d = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        if (rdata_i == key_q) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          if (key_q < rdata_i) begin
            hi_d = mid_q - idx_t'(1);
          end else begin
            lo_d = mid_q + idx_t'(1);
          end
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
  end

  assign raddr_o     = ADDR_W'($unsigned(mid));
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign found_o     = found_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search_top.sv =====
// Top level of the sorted-table binary search: stream ports, load path into
// the table RAM, search engine and output register. Uses stbs_pkg, stbs_ram,
// stbs_engine.
//
//  channel   dir  carries                        word accepted when
//  s_axis    in   load or search request         tvalid && tready
//  m_axis    out  found flag, one per search     tvalid && tready
//
// A load writes the table as it is accepted. A search probe is a RAM read
// (PROBE), then a compare (CMP); at most 9 probes for 256 entries, plus entry,
// empty-range check and hand-off. The table RAM read port sets the pace.
// s_axis_tready is high only while the engine is idle; a result waiting in
// the output register does not block the next word until the engine has a
// second result ready. Reset clears control only; table contents are
// undefined until loaded.
`default_nettype none

module sorted_table_binary_search_top import stbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] entry_index, [39:8] value, [47:40] first_index,
  // [56:48] last_index, [63:57] zero
  input  logic [63:0] s_axis_tdata_i,
  // [0] action
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] found, [7:1] zero
  output logic [7:0]  m_axis_tdata_o
);

  logic                      in_accept;
  logic                      is_load;
  logic [ENTRY_W-1:0]        entry_index;
  logic signed [VALUE_W-1:0] value;
  logic [FIRST_W-1:0]        first_index;
  logic signed [LAST_W-1:0]  last_index;
  logic                      entry_ok;

  stbs_req_t         req;
  logic              eng_idle;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  word_t             ram_rdata;
  logic              res_valid;
  logic              res_ready;
  logic              res_found;

  logic out_valid_q, out_valid_d;
  logic out_found_q, out_found_d;

  assign entry_index = s_axis_tdata_i[7:0];
  assign value       = s_axis_tdata_i[39:8];
  assign first_index = s_axis_tdata_i[47:40];
  assign last_index  = s_axis_tdata_i[56:48];
  assign is_load     = (s_axis_tuser_i[0] == ACT_LOAD);

  assign s_axis_tready_o = eng_idle;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign entry_ok        = (32'(entry_index) < 32'(TABLE_DEPTH));
  assign ram_we          = in_accept && is_load && entry_ok;

  assign req.key = word_from_field(value);
  assign req.lo  = idx_t'({1'b0, first_index});
  assign req.hi  = IDX_W'(last_index);

  stbs_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ADDR_W'(entry_index)),
    .wdata_i(req.key),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  stbs_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept && !is_load),
    .req_i      (req),
    .idle_o     (eng_idle),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .found_o    (res_found)
  );

  // Output register: takes a result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_found_d = res_found;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_found_q};

  // Table is never written while a probe read is in flight
  a_no_write_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write during search read");

  // A search word closes the input until the engine is idle again
  a_search_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !is_load) |=> !s_axis_tready_o)
    else $error("input open during search");

  // A load never produces a result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_load && !out_valid_q) |=> !m_axis_tvalid_o)
    else $error("result after load");

  // A finished search is held until the output register takes it
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_found)))
    else $error("search result dropped");

endmodule

`default_nettype wire
